>>> src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define CFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("cfr assertion failed");

// check a property on every clock edge, reset included
`define CFR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("cfr assertion failed");

`endif

>>> src/cfr_pkg.sv
package cfr_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_FRAGS   = 32;
   localparam int CHUNK_BYTES = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int POS_W       = $clog2(MAX_FRAGS);
   localparam int ADDR_W      = SLOT_W + POS_W;
   localparam int DEPTH       = SLOTS * MAX_FRAGS;
   localparam int CNT_W       = 6;
   localparam logic [7:0] EVICT_OFFSET = 8'd127;

   // register indexes of the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_B = 2'd1;

   // one stored fragment
   typedef struct packed {
      logic [3:0]  bytes;
      logic [63:0] chunk;
   } frag_type;

   // one result word
   typedef struct packed {
      logic [7:0]  source;
      logic [7:0]  dest;
      logic [2:0]  prio;
      logic [63:0] chunk;
      logic [3:0]  bytes;
      logic        last;
   } rsp_type;

   // saturate the byte count to the chunk size
   function automatic logic [3:0] sat_bytes(input logic [3:0] n);
      logic [3:0] r;
      r = (n > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : n;
      return r;
   endfunction

   // clear payload bytes beyond the count
   function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] n);
      logic [63:0] r;
      r = d;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) >= n) r[i*8 +: 8] = 8'd0;
      end
      return r;
   endfunction

endpackage

>>> src/cfr_frag_store.sv
module cfr_frag_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [cfr_pkg::ADDR_W-1:0] wr_addr,
   input  cfr_pkg::frag_type        wr_data,
   input  logic [cfr_pkg::ADDR_W-1:0] rd_addr,
   output cfr_pkg::frag_type        rd_data
);
   import cfr_pkg::*;

   frag_type mem [DEPTH];
   frag_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cfr_rsp_reg.sv
module cfr_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cfr_pkg::rsp_type load_data,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfr_pkg::rsp_type rsp_data
);
   import cfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `include "assert_macros.svh"
   `CFR_ASSERT(a_load_when_free, clock, reset, load |-> free)
   `CFR_ASSERT(a_load_shows, clock, reset, load |=> rsp_valid)

endmodule

>>> src/can_fragment_reassembler_top.sv
// can fragment reassembler
// req_ channel: one received can frame per word (valid/ready). frames whose
// dest_id matches neither csr register are dropped; a frame with
// frag_total_m1 zero comes out on its own as a one-word message.
// fragments are stored per (source, message id) slot; when a slot's count
// reaches frag_total_m1+1 the stored chunks leave on the rsp_ channel in
// sequence order, rsp_last on the final one.
// csr_ port: write enable, index (0 = accept_dest_a, 1 = accept_dest_b), data.
// steps: a multi-frame fragment is accepted, then takes 8 slot scan steps
// through one key comparator, then an update; a completing fragment then
// emits each chunk by a store read, then a load into the output register.
// a single frame is accepted, then loaded; a dropped frame is only accepted.
// req_ready is high only while the sequencer is idle.
// when the receiver stalls, the output register holds its word and the
// sequencer waits; no word is lost.
// reset (synchronous) clears the slot table and csr registers; fragment
// memory needs no clearing pass.
module can_fragment_reassembler_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [cfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                  csr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_source_id,
   input  logic [7:0]                  req_dest_id,
   input  logic [2:0]                  req_prio,
   input  logic [7:0]                  req_message_id,
   input  logic [4:0]                  req_seq_num,
   input  logic [4:0]                  req_frag_total_m1,
   input  logic [3:0]                  req_byte_count,
   input  logic [63:0]                 req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_source,
   output logic [7:0]                  rsp_out_dest,
   output logic [2:0]                  rsp_out_prio,
   output logic [63:0]                 rsp_out_chunk,
   output logic [3:0]                  rsp_out_bytes,
   output logic                        rsp_out_last
);
   import cfr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_UPD    = 3'd2;
   localparam logic [2:0] ST_RD     = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_SINGLE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [7:0] dest_a_ff, dest_b_ff;

   // captured frame
   logic [7:0]  src_ff, dst_ff, mid_ff;
   logic [2:0]  prio_ff;
   logic [4:0]  seq_ff, tot_ff;
   logic [3:0]  len_ff;
   logic [63:0] pay_ff;

   // slot table
   logic [SLOTS-1:0] slot_valid_ff;
   logic [15:0]      slot_key_ff [SLOTS];
   logic [CNT_W-1:0] slot_rcv_ff [SLOTS];
   logic [10:0]      slot_hdr_ff [SLOTS];

   // scan results
   logic [SLOT_W-1:0] idx_ff;
   logic              hit_ff, ev_ff, free_ff;
   logic [SLOT_W-1:0] hit_idx_ff, ev_idx_ff, free_idx_ff;
   logic [CNT_W-1:0]  hit_rcv_ff;
   logic [10:0]       hit_hdr_ff;

   // emission
   logic [SLOT_W-1:0] es_ff;
   logic [POS_W-1:0]  k_ff, last_k_ff;
   logic [10:0]       ehdr_ff;

   logic        accept, dest_ok;
   logic [3:0]  in_len;
   logic [15:0] key_cur, key_old;
   logic        cmp_v, cmp_hit, cmp_ev;

   // update decisions
   logic              upd_drop, upd_done;
   logic [SLOT_W-1:0] upd_s;
   logic [CNT_W-1:0]  upd_rcv, upd_rcv_new, upd_exp;
   logic [10:0]       upd_hdr;
   logic [POS_W-1:0]  upd_last;

   logic     out_free, out_load, emit_ld;
   rsp_type  out_data, rsp_data;
   frag_type rd_frag, wr_frag;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_len    = sat_bytes(req_byte_count);
   assign dest_ok   = (req_dest_id == dest_a_ff) || (req_dest_id == dest_b_ff);

   // shared key comparator over the scanned slot
   assign key_cur = {src_ff, mid_ff};
   assign key_old = {src_ff, 8'(mid_ff + EVICT_OFFSET)};
   assign cmp_v   = slot_valid_ff[idx_ff];
   assign cmp_hit = cmp_v && (slot_key_ff[idx_ff] == key_cur);
   assign cmp_ev  = cmp_v && (slot_key_ff[idx_ff] == key_old);

   // slot choice after the scan
   always_comb begin
      upd_drop = 1'b0;
      upd_s    = hit_idx_ff;
      upd_rcv  = hit_rcv_ff;
      upd_hdr  = hit_hdr_ff;
      if (!hit_ff) begin
         upd_rcv = '0;
         upd_hdr = {dst_ff, prio_ff};
         if (free_ff && (!ev_ff || free_idx_ff < ev_idx_ff)) begin
            upd_s = free_idx_ff;
         end else if (ev_ff) begin
            upd_s = ev_idx_ff;
         end else begin
            upd_drop = 1'b1;
         end
      end
      upd_rcv_new = (upd_rcv < CNT_W'(63)) ? upd_rcv + 1'b1 : upd_rcv;
      upd_exp     = CNT_W'(tot_ff) + 1'b1;
      upd_done    = (upd_rcv_new >= upd_exp);
      upd_last    = (int'(tot_ff) >= MAX_FRAGS) ? POS_W'(MAX_FRAGS - 1) : POS_W'(tot_ff);
   end

   assign wr_frag = '{bytes: len_ff, chunk: pay_ff};

   cfr_frag_store u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPD && !upd_drop),
      .wr_addr ({upd_s, seq_ff[POS_W-1:0]}),
      .wr_data (wr_frag),
      .rd_addr ({es_ff, k_ff}),
      .rd_data (rd_frag)
   );

   // output word selection
   assign emit_ld  = (state_ff == ST_EMIT) && out_free;
   assign out_load = emit_ld || ((state_ff == ST_SINGLE) && out_free);
   always_comb begin
      if (state_ff == ST_SINGLE) begin
         out_data = '{source: src_ff, dest: dst_ff, prio: prio_ff, chunk: pay_ff,
                      bytes: len_ff, last: 1'b1};
      end else begin
         out_data = '{source: src_ff, dest: ehdr_ff[10:3], prio: ehdr_ff[2:0],
                      chunk: rd_frag.chunk, bytes: rd_frag.bytes,
                      last: (k_ff == last_k_ff)};
      end
   end

   cfr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_source = rsp_data.source;
   assign rsp_out_dest   = rsp_data.dest;
   assign rsp_out_prio   = rsp_data.prio;
   assign rsp_out_chunk  = rsp_data.chunk;
   assign rsp_out_bytes  = rsp_data.bytes;
   assign rsp_out_last   = rsp_data.last;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && dest_ok) begin
               if (req_frag_total_m1 == 5'd0) begin
                  state_in = ST_SINGLE;
               end else if (int'(req_seq_num) < MAX_FRAGS) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == SLOT_W'(SLOTS - 1)) state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in = (!upd_drop && upd_done) ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ld) state_in = (k_ff == last_k_ff) ? ST_IDLE : ST_RD;
         end
         ST_SINGLE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dest_a_ff     <= 8'd0;
         dest_b_ff     <= 8'd0;
         slot_valid_ff <= '0;
         for (int i = 0; i < SLOTS; i++) slot_rcv_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == CSR_DEST_A) dest_a_ff <= csr_data;
         if (csr_we && csr_index == CSR_DEST_B) dest_b_ff <= csr_data;
         if (state_ff == ST_UPD) begin
            if (!hit_ff && ev_ff) begin
               slot_valid_ff[ev_idx_ff] <= 1'b0;
               slot_rcv_ff[ev_idx_ff]   <= '0;
            end
            if (!upd_drop) begin
               slot_valid_ff[upd_s] <= !upd_done;
               slot_rcv_ff[upd_s]   <= upd_done ? '0 : upd_rcv_new;
            end
         end
      end
   end

   // frame capture, scan and emission datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff  <= req_source_id;
         dst_ff  <= req_dest_id;
         prio_ff <= req_prio;
         mid_ff  <= req_message_id;
         seq_ff  <= req_seq_num;
         tot_ff  <= req_frag_total_m1;
         len_ff  <= in_len;
         pay_ff  <= keep_bytes(req_payload, in_len);
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         ev_ff   <= 1'b0;
         free_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
         if (cmp_hit) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
            hit_rcv_ff <= slot_rcv_ff[idx_ff];
            hit_hdr_ff <= slot_hdr_ff[idx_ff];
         end
         if (cmp_ev) begin
            ev_ff     <= 1'b1;
            ev_idx_ff <= idx_ff;
         end
         if (!cmp_v && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
      if (state_ff == ST_UPD) begin
         es_ff     <= upd_s;
         k_ff      <= '0;
         last_k_ff <= upd_last;
         ehdr_ff   <= upd_hdr;
         if (!upd_drop && !hit_ff) begin
            slot_key_ff[upd_s] <= key_cur;
            slot_hdr_ff[upd_s] <= upd_hdr;
         end
      end
      if (emit_ld) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   `include "assert_macros.svh"
   `CFR_ASSERT(a_busy_during_scan, clock, reset, (state_ff == ST_SCAN) |-> !req_ready)
   `CFR_ASSERT(a_emit_in_range, clock, reset, emit_ld |-> (k_ff <= last_k_ff))
   `CFR_ASSERT(a_last_ends, clock, reset, (emit_ld && k_ff == last_k_ff) |=> req_ready)

endmodule

>>> test/can_fragment_reassembler_top_tb.sv
module can_fragment_reassembler_top_tb;
   import cfr_pkg::*;

   typedef struct {
      logic [7:0]  source_id;
      logic [7:0]  dest_id;
      logic [2:0]  prio;
      logic [7:0]  message_id;
      logic [4:0]  seq_num;
      logic [4:0]  frag_total_m1;
      logic [3:0]  byte_count;
      logic [63:0] payload;
   } frame_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEST_A;
   logic [7:0]           csr_data = 8'd0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_source_id = 8'd0;
   logic [7:0]           req_dest_id = 8'd0;
   logic [2:0]           req_prio = 3'd0;
   logic [7:0]           req_message_id = 8'd0;
   logic [4:0]           req_seq_num = 5'd0;
   logic [4:0]           req_frag_total_m1 = 5'd0;
   logic [3:0]           req_byte_count = 4'd0;
   logic [63:0]          req_payload = 64'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_out_source;
   logic [7:0]           rsp_out_dest;
   logic [2:0]           rsp_out_prio;
   logic [63:0]          rsp_out_chunk;
   logic [3:0]           rsp_out_bytes;
   logic                 rsp_out_last;

   can_fragment_reassembler_top dut (.*);

   always #2 clock = ~clock;

   // predictor copy of the accept registers and the slot table
   logic [7:0]  dest_a, dest_b;
   logic        open_slot [SLOTS];
   logic [15:0] open_key [SLOTS];
   logic [5:0]  rcv_count [SLOTS];
   logic [7:0]  hdr_dest [SLOTS];
   logic [2:0]  hdr_prio [SLOTS];
   logic [63:0] chunk_mem [SLOTS][MAX_FRAGS];
   logic [3:0]  bytes_mem [SLOTS][MAX_FRAGS];
   bit          ever_written [SLOTS][MAX_FRAGS];

   rsp_type pending_words[$];
   int      errors = 0;
   int      send_idle = 0;
   int      recv_stall = 0;
   int      hold_cycles = 0;
   int      quiet_cycles = 0;

   function automatic int lookup_slot(logic [15:0] k);
      for (int s = 0; s < SLOTS; s++)
         if (open_slot[s] && open_key[s] == k) return s;
      return -1;
   endfunction

   // work out the words a frame causes; with commit clear nothing changes and
   // the return flags a completion that would read a never-written position
   function automatic bit reassemble(frame_type f, bit commit);
      logic [3:0]  len;
      logic [63:0] pay;
      logic [15:0] k;
      logic [5:0]  rcv;
      int          s, victim, n;
      bit          fresh, bad;
      rsp_type     w;
      len = (f.byte_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : f.byte_count;
      pay = f.payload;
      for (int i = 0; i < 8; i++)
         if (i >= len) pay[i*8 +: 8] = 8'd0;
      bad = 0;
      if (f.dest_id != dest_a && f.dest_id != dest_b) return 0;
      if (f.frag_total_m1 == 0) begin
         if (commit) begin
            w = '{f.source_id, f.dest_id, f.prio, pay, len, 1'b1};
            pending_words = {pending_words, w};
         end
         return 0;
      end
      k = {f.source_id, f.message_id};
      s = lookup_slot(k);
      fresh = (s < 0);
      victim = -1;
      if (fresh) begin
         victim = lookup_slot({f.source_id, f.message_id + EVICT_OFFSET});
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!open_slot[i] || i == victim) s = i;
         if (commit && victim >= 0) begin
            open_slot[victim] = 0;
            rcv_count[victim] = 0;
         end
         if (s < 0) return 0;
      end
      rcv = fresh ? 6'd0 : rcv_count[s];
      if (rcv < 6'd63) rcv++;
      n = int'(f.frag_total_m1) + 1;
      if (rcv >= n)
         for (int i = 0; i < n; i++)
            if (i != f.seq_num && !ever_written[s][i]) bad = 1;
      if (!commit) return bad;
      if (fresh) begin
         open_slot[s] = 1;
         open_key[s] = k;
         hdr_dest[s] = f.dest_id;
         hdr_prio[s] = f.prio;
      end
      chunk_mem[s][f.seq_num] = pay;
      bytes_mem[s][f.seq_num] = len;
      ever_written[s][f.seq_num] = 1;
      rcv_count[s] = rcv;
      if (rcv >= n) begin
         for (int i = 0; i < n; i++) begin
            w = '{f.source_id, hdr_dest[s], hdr_prio[s], chunk_mem[s][i], bytes_mem[s][i],
                  1'(i == n - 1)};
            pending_words = {pending_words, w};
         end
         open_slot[s] = 0;
         rcv_count[s] = 0;
      end
      return bad;
   endfunction

   // offer one frame, unless its completion would read a never-written position, and wait for it to be taken
   task automatic send_frame(frame_type f);
      if (reassemble(f, 0)) return;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_id <= f.source_id;
      req_dest_id <= f.dest_id;
      req_prio <= f.prio;
      req_message_id <= f.message_id;
      req_seq_num <= f.seq_num;
      req_frag_total_m1 <= f.frag_total_m1;
      req_byte_count <= f.byte_count;
      req_payload <= f.payload;
      do @(posedge clock); while (!req_ready);
      void'(reassemble(f, 1));
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every expected word is out, then for the block to go quiet
   task automatic drain();
      idle_input();
      wait (pending_words.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // caller drops the write enable after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (idx == CSR_DEST_A) dest_a = val;
      else dest_b = val;
   endtask

   task automatic set_dests(logic [7:0] a, logic [7:0] b);
      drain();
      write_reg(CSR_DEST_A, a);
      write_reg(CSR_DEST_B, b);
      csr_we <= 1'b0;
   endtask

   function automatic frame_type make_frame(logic [7:0] src, logic [7:0] dst, logic [7:0] mid,
                                            int seq, int tot, logic [3:0] nb);
      frame_type f;
      f.source_id = src;
      f.dest_id = dst;
      f.prio = 3'($urandom_range(7));
      f.message_id = mid;
      f.seq_num = 5'(seq);
      f.frag_total_m1 = 5'(tot);
      f.byte_count = nb;
      f.payload = {$urandom, $urandom};
      return f;
   endfunction

   // close every open slot: an evicting fragment takes it over, a second one completes it
   task automatic close_open_slots();
      logic [7:0] src, mid;
      for (int pass = 0; pass < 3; pass++)
         for (int s = 0; s < SLOTS; s++)
            if (open_slot[s]) begin
               src = open_key[s][15:8];
               mid = open_key[s][7:0] + 8'd129;
               send_frame(make_frame(src, dest_a, mid, 0, 1, 4'd8));
               send_frame(make_frame(src, dest_a, mid, 1, 1, 4'd3));
            end
   endtask

   task automatic test_directed();
      frame_type f;
      // reset values accept destination zero
      send_frame(make_frame(8'h01, 8'h00, 8'h00, 0, 0, 4'd8));
      set_dests(8'h12, 8'h34);
      // dropped destination, then byte count saturation and an empty frame
      send_frame(make_frame(8'h01, 8'h99, 8'h00, 0, 0, 4'd8));
      f = make_frame(8'hFF, 8'h34, 8'hFF, 31, 0, 4'd15);
      f.payload = '1;
      f.prio = 3'd7;
      send_frame(f);
      send_frame(make_frame(8'h00, 8'h12, 8'h00, 0, 0, 4'd0));
      // three fragments out of order
      send_frame(make_frame(8'h05, 8'h12, 8'h0A, 2, 2, 4'd5));
      send_frame(make_frame(8'h05, 8'h34, 8'h0A, 0, 2, 4'd8));
      send_frame(make_frame(8'h05, 8'h12, 8'h0A, 1, 2, 4'd9));
      // duplicate position completes early, the gap shows stale data
      send_frame(make_frame(8'h06, 8'h12, 8'h20, 0, 2, 4'd2));
      send_frame(make_frame(8'h06, 8'h12, 8'h20, 0, 2, 4'd7));
      send_frame(make_frame(8'h06, 8'h12, 8'h20, 1, 2, 4'd1));
      // a new message id evicts the one 129 below it
      send_frame(make_frame(8'h07, 8'h12, 8'h0A, 0, 3, 4'd8));
      send_frame(make_frame(8'h07, 8'h12, 8'h8B, 0, 1, 4'd8));
      send_frame(make_frame(8'h07, 8'h12, 8'h8B, 1, 1, 4'd8));
      close_open_slots();
      // fill the table, a ninth message is dropped, then finish all eight
      for (int i = 0; i < SLOTS; i++)
         send_frame(make_frame(8'(8'h40 + i), 8'h12, 8'(i), 0, 1, 4'd8));
      send_frame(make_frame(8'h50, 8'h12, 8'h00, 0, 1, 4'd8));
      for (int i = 0; i < SLOTS; i++)
         send_frame(make_frame(8'(8'h40 + i), 8'h34, 8'(i), 1, 1, 4'(i)));
      drain();
   endtask

   function automatic logic [7:0] pick_dest();
      case ($urandom_range(9))
         0: return 8'($urandom_range(255));
         1, 2, 3, 4: return dest_a;
         default: return dest_b;
      endcase
   endfunction

   task automatic test_random(int items);
      int sent, tot, kind, order[MAX_FRAGS], j, tmp;
      logic [7:0] src, mid;
      frame_type f;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(99);
         if (kind < 12) begin
            // noise: any field value at all
            f = make_frame(8'($urandom), pick_dest(), 8'($urandom), $urandom_range(31),
                           ($urandom_range(1) ? 0 : $urandom_range(31)), 4'($urandom));
            send_frame(f);
            sent++;
         end else begin
            src = 8'($urandom);
            mid = 8'($urandom);
            tot = ($urandom_range(11) == 0) ? $urandom_range(5, 31) : $urandom_range(1, 4);
            for (int i = 0; i <= tot; i++) order[i] = i;
            for (int i = tot; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            // a broken message loses or repeats one fragment
            if (kind < 20) order[$urandom_range(tot)] = order[$urandom_range(tot)];
            for (int i = 0; i <= tot; i++) begin
               if (kind < 20 && i == tot && kind < 16) break;
               send_frame(make_frame(src, pick_dest(), mid, order[i], tot,
                                     ($urandom_range(5) == 0) ? 4'($urandom) :
                                     4'($urandom_range(8))));
               sent++;
            end
         end
         if ($urandom_range(7) == 0) close_open_slots();
      end
      close_open_slots();
      drain();
   endtask

   // receiver holds off long while frames keep coming
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 6; i++)
         send_frame(make_frame(8'(i), dest_a, 8'h00, 0, 0, 4'd8));
      for (int i = 0; i < 4; i++)
         send_frame(make_frame(8'h77, dest_b, 8'h33, i, 3, 4'd8));
      drain();
   endtask

   // receiver side: random stalls and the long hold
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // compare each word with the oldest expectation
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_source, rsp_out_dest, rsp_out_prio, rsp_out_chunk, rsp_out_bytes,
                 rsp_out_last};
         if (pending_words.size() == 0) begin
            $display("%0t unexpected word %p", $time, got);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               $display("%0t mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL can_fragment_reassembler_top");
         $finish;
      end
   end

   initial begin
      dest_a = 8'd0;
      dest_b = 8'd0;
      for (int s = 0; s < SLOTS; s++) begin
         open_slot[s] = 0;
         rcv_count[s] = 0;
         for (int i = 0; i < MAX_FRAGS; i++) ever_written[s][i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      set_dests(8'h00, 8'hFF);
      test_random(80);
      send_idle = 88;
      set_dests(8'hFF, 8'h00);
      test_random(80);
      send_idle = 0;
      recv_stall = 88;
      set_dests(8'($urandom), 8'($urandom));
      test_random(80);
      send_idle = 15;
      recv_stall = 15;
      set_dests(8'h5A, 8'h5A);
      test_random(80);
      drain();
      if (errors == 0) $display("PASS can_fragment_reassembler_top");
      else $display("FAIL can_fragment_reassembler_top");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/cfr_pkg.sv
src/cfr_frag_store.sv
src/cfr_rsp_reg.sv
src/can_fragment_reassembler_top.sv
test/can_fragment_reassembler_top_tb.sv
